// File: sv/wrms_pkg.sv
package wrms_pkg;

   // number format and vector length
   localparam int FRAC_BITS  = 16;
   localparam int MAX_LENGTH = 65536;

   // fixed field widths
   localparam int WORD_W = 32;
   localparam int SUM_W  = 64;

   // derived datapath widths
   localparam int CNT_W    = $clog2(MAX_LENGTH + 1);
   localparam int DMAG_W   = WORD_W + 1;
   localparam int NUM_W    = DMAG_W + FRAC_BITS;
   localparam int NUMHI_W  = NUM_W - WORD_W;
   localparam int WEIGHT_W = 2 * WORD_W - FRAC_BITS + 1;
   localparam int DIV_W    = (WEIGHT_W > CNT_W) ? WEIGHT_W : CNT_W;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int SQREM_W  = ROOT_W + 1;

   // iteration counts of the shared divider and the root unit
   localparam int ELEM_DIV_STEPS = WORD_W;
   localparam int MEAN_DIV_STEPS = SUM_W;
   localparam int SQRT_STEPS     = ROOT_W;
   localparam int STEP_W         = $clog2(MEAN_DIV_STEPS);

   localparam logic [WORD_W-1:0] WORD_MAX = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_REL_TOL  = 2'd0,
      CSR_ABS_TOL  = 2'd1,
      CSR_NORM_TOL = 2'd2
   } csr_index_type;

   localparam logic [WORD_W-1:0] REL_TOL_RESET  = 32'd66;
   localparam logic [WORD_W-1:0] ABS_TOL_RESET  = 32'd1;
   localparam logic [WORD_W-1:0] NORM_TOL_RESET = 32'd65536;

   // controller to datapath commands
   typedef struct packed {
      logic load_in;
      logic do_mul;
      logic do_weight;
      logic div_init_elem;
      logic div_init_mean;
      logic div_step;
      logic do_square;
      logic do_accum;
      logic sqrt_init;
      logic sqrt_step;
      logic load_out;
      logic out_sat;
   } wrms_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last;
      logic first;
      logic clipped;
      logic out_free;
   } wrms_sts_type;

endpackage

// File: sv/wrms_ctrl.sv
module wrms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wrms_pkg::wrms_sts_type sts,
   output wrms_pkg::wrms_cmd_type cmd
);
   import wrms_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_WEIGHT,
      ST_DIV_INIT,
      ST_DIV,
      ST_SQUARE,
      ST_ACCUM,
      ST_CHECK,
      ST_MEAN_DIV,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_FINISH,
      ST_FINISH_SAT
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic               accept;

   // input side takes a transaction only when the datapath is free
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // next state and step count
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MUL;
         end
         ST_MUL:      state_in = ST_WEIGHT;
         ST_WEIGHT:   state_in = ST_DIV_INIT;
         ST_DIV_INIT: begin
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ELEM_DIV_STEPS - 1)) state_in = ST_SQUARE;
         end
         ST_SQUARE:   state_in = ST_ACCUM;
         ST_ACCUM: begin
            state_in = sts.last ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            step_in  = '0;
            state_in = (sts.first || sts.clipped) ? ST_FINISH_SAT : ST_MEAN_DIV;
         end
         ST_MEAN_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(MEAN_DIV_STEPS - 1)) state_in = ST_SQRT_INIT;
         end
         ST_SQRT_INIT: begin
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) state_in = ST_FINISH;
         end
         ST_FINISH, ST_FINISH_SAT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      cmd               = '0;
      cmd.load_in       = accept;
      cmd.do_mul        = (state_ff == ST_MUL);
      cmd.do_weight     = (state_ff == ST_WEIGHT);
      cmd.div_init_elem = (state_ff == ST_DIV_INIT);
      cmd.div_init_mean = (state_ff == ST_CHECK) && !(sts.first || sts.clipped);
      cmd.div_step      = (state_ff == ST_DIV) || (state_ff == ST_MEAN_DIV);
      cmd.do_square     = (state_ff == ST_SQUARE);
      cmd.do_accum      = (state_ff == ST_ACCUM);
      cmd.sqrt_init     = (state_ff == ST_SQRT_INIT);
      cmd.sqrt_step     = (state_ff == ST_SQRT);
      cmd.load_out      = ((state_ff == ST_FINISH) || (state_ff == ST_FINISH_SAT))
                          && sts.out_free;
      cmd.out_sat       = (state_ff == ST_FINISH_SAT);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: sv/wrms_dp.sv
module wrms_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  wrms_pkg::wrms_cmd_type              cmd,
   output wrms_pkg::wrms_sts_type              sts,
   input  logic        [wrms_pkg::WORD_W-1:0]  rel_tol,
   input  logic        [wrms_pkg::WORD_W-1:0]  abs_tol,
   input  logic        [wrms_pkg::WORD_W-1:0]  norm_tol,
   input  logic signed [wrms_pkg::WORD_W-1:0]  req_current_value,
   input  logic signed [wrms_pkg::WORD_W-1:0]  req_previous_value,
   input  logic                                req_last_element,
   input  logic                                req_first_iteration,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [wrms_pkg::WORD_W-1:0]  rsp_norm_value,
   output logic                                rsp_converged,
   output logic                                rsp_norm_saturated
);
   import wrms_pkg::*;

   // captured transaction
   logic [WORD_W-1:0]   cur_ff;
   logic [WORD_W-1:0]   prev_ff;
   logic                last_ff;
   logic                first_ff;

   // element pipeline registers
   logic [SUM_W-1:0]    prod_ff;
   logic [SUM_W-1:0]    prod_in;
   logic [DMAG_W-1:0]   dmag_ff;
   logic [DMAG_W-1:0]   dmag_in;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [WEIGHT_W-1:0] weight_in;
   logic                q_zero_ff;
   logic                q_clip_ff;
   logic [SUM_W-1:0]    sq_ff;

   // accumulation state
   logic [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                clipped_ff;

   // shared restoring divider
   logic [DIV_W-1:0]    div_rem_ff;
   logic [DIV_W-1:0]    div_den_ff;
   logic [SUM_W-1:0]    div_quo_ff;

   // square root unit
   logic [SUM_W-1:0]    sqrt_rad_ff;
   logic [SQREM_W-1:0]  sqrt_rem_ff;
   logic [ROOT_W-1:0]   sqrt_root_ff;

   // result register
   logic                out_valid_ff;
   logic [WORD_W-1:0]   out_norm_ff;
   logic                out_conv_ff;
   logic                out_sat_ff;

   logic [WORD_W-1:0]   cur_mag;
   logic [DMAG_W-1:0]   diff;
   logic [NUM_W-1:0]    num;
   logic [NUMHI_W-1:0]  num_hi;
   logic [WORD_W-1:0]   q_sel;
   logic [SUM_W:0]      sum_ext;
   logic [DIV_W:0]      div_shift;
   logic [DIV_W:0]      div_den_ext;
   logic [SQREM_W+1:0]  sqrt_t;
   logic [SQREM_W+1:0]  sqrt_trial;
   logic [CNT_W-1:0]    mean_n;

   // magnitude of the current element and of the difference
   always_comb begin
      cur_mag = cur_ff[WORD_W-1] ? (~cur_ff + 1'b1) : cur_ff;
      diff    = {cur_ff[WORD_W-1], cur_ff} - {prev_ff[WORD_W-1], prev_ff};
      dmag_in = diff[DMAG_W-1] ? (~diff + 1'b1) : diff;
      prod_in = SUM_W'(rel_tol) * SUM_W'(cur_mag);
   end

   // weight and scaled numerator
   assign weight_in = WEIGHT_W'(prod_ff[SUM_W-1:FRAC_BITS]) + WEIGHT_W'(abs_tol);
   assign num       = {dmag_ff, {FRAC_BITS{1'b0}}};
   assign num_hi    = num[NUM_W-1:WORD_W];

   // quotient after zero and overflow handling
   always_comb begin
      if (q_zero_ff)      q_sel = '0;
      else if (q_clip_ff) q_sel = WORD_MAX;
      else                q_sel = div_quo_ff[WORD_W-1:0];
   end

   assign sum_ext     = {1'b0, sum_ff} + {1'b0, sq_ff};
   assign div_shift   = {div_rem_ff, div_quo_ff[SUM_W-1]};
   assign div_den_ext = {1'b0, div_den_ff};
   assign sqrt_t      = {sqrt_rem_ff, sqrt_rad_ff[SUM_W-1 -: 2]};
   assign sqrt_trial  = {1'b0, sqrt_root_ff, 2'b01};
   assign mean_n      = (count_ff == '0) ? CNT_W'(1) : count_ff;

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cur_ff   <= req_current_value;
         prev_ff  <= req_previous_value;
         last_ff  <= req_last_element;
         first_ff <= req_first_iteration;
      end
      if (cmd.do_mul) begin
         prod_ff <= prod_in;
         dmag_ff <= dmag_in;
      end
      if (cmd.do_weight) weight_ff <= weight_in;
      if (cmd.do_square) sq_ff <= SUM_W'(q_sel) * SUM_W'(q_sel);

      // divider: load for element or mean, then one quotient bit per step
      if (cmd.div_init_elem) begin
         q_zero_ff  <= (dmag_ff == '0);
         q_clip_ff  <= (dmag_ff != '0) && (WEIGHT_W'(num_hi) >= weight_ff);
         div_rem_ff <= DIV_W'(num_hi);
         div_den_ff <= DIV_W'(weight_ff);
         div_quo_ff <= {num[WORD_W-1:0], {(SUM_W - WORD_W){1'b0}}};
      end else if (cmd.div_init_mean) begin
         div_rem_ff <= '0;
         div_den_ff <= DIV_W'(mean_n);
         div_quo_ff <= sum_ff;
      end else if (cmd.div_step) begin
         if (div_shift >= div_den_ext) begin
            div_rem_ff <= div_shift[DIV_W-1:0] - div_den_ff;
            div_quo_ff <= {div_quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            div_rem_ff <= div_shift[DIV_W-1:0];
            div_quo_ff <= {div_quo_ff[SUM_W-2:0], 1'b0};
         end
      end

      // square root: one root bit per step
      if (cmd.sqrt_init) begin
         sqrt_rad_ff  <= div_quo_ff;
         sqrt_rem_ff  <= '0;
         sqrt_root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sqrt_rad_ff <= {sqrt_rad_ff[SUM_W-3:0], 2'b00};
         if (sqrt_t >= sqrt_trial) begin
            sqrt_rem_ff  <= SQREM_W'(sqrt_t - sqrt_trial);
            sqrt_root_ff <= {sqrt_root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            sqrt_rem_ff  <= sqrt_t[SQREM_W-1:0];
            sqrt_root_ff <= {sqrt_root_ff[ROOT_W-2:0], 1'b0};
         end
      end

      // result payload
      if (cmd.load_out) begin
         if (cmd.out_sat) begin
            out_norm_ff <= WORD_MAX;
            out_conv_ff <= 1'b0;
            out_sat_ff  <= 1'b1;
         end else begin
            out_norm_ff <= sqrt_root_ff;
            out_conv_ff <= (sqrt_root_ff < norm_tol);
            out_sat_ff  <= 1'b0;
         end
      end
   end

   // accumulation state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         clipped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            sum_ff     <= '0;
            count_ff   <= '0;
            clipped_ff <= 1'b0;
         end else begin
            if (cmd.do_square && q_clip_ff && !q_zero_ff) clipped_ff <= 1'b1;
            if (cmd.do_accum) begin
               if (sum_ext[SUM_W]) begin
                  sum_ff     <= SUM_MAX;
                  clipped_ff <= 1'b1;
               end else begin
                  sum_ff <= sum_ext[SUM_W-1:0];
               end
               if (count_ff < CNT_W'(MAX_LENGTH)) count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.load_out)                  out_valid_ff <= 1'b1;
         else if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
      end
   end

   // status to the controller
   always_comb begin
      sts.last     = last_ff;
      sts.first    = first_ff;
      sts.clipped  = clipped_ff;
      sts.out_free = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_norm_value     = out_norm_ff;
   assign rsp_converged      = out_conv_ff;
   assign rsp_norm_saturated = out_sat_ff;

   // an overflowing element quotient must mark the vector as clipped
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_square && q_clip_ff && !q_zero_ff && !cmd.load_out |=> clipped_ff)
      else $error("clipped quotient did not set the sticky flag");

   // element divider keeps its partial remainder below the weight
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && !q_clip_ff && !q_zero_ff |-> div_rem_ff < div_den_ff)
      else $error("divider remainder out of range");

   // root remainder never exceeds twice the partial root
   assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_step |-> sqrt_rem_ff <= {sqrt_root_ff, 1'b0})
      else $error("square root remainder out of range");

   // element count saturates at the vector limit
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LENGTH))
      else $error("element count past its limit");

   // a saturated result is the maximum norm and never converged
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_sat_ff |-> !out_conv_ff && (out_norm_ff == WORD_MAX))
      else $error("saturated result with wrong norm or flag");

endmodule

// File: sv/wrms_update_norm_test.sv
// Weighted RMS norm convergence test on Q16.16 data. Each req_ transaction carries one
// element of the current and previous vectors; the block accumulates the square of
// (cur - prev) / (rtol*|cur| + atol) and, on the transaction marked last, returns one
// rsp_ transaction with sqrt(sum / N), a converged flag (norm below norm_tolerance) and
// a saturation flag. A vector marked first iteration, or one whose quotient or sum
// overflowed, reports the maximum norm, saturated and not converged. Each element
// passes through the 32-step restoring divider, which forms the element quotient one
// bit per cycle. The element marked last adds a 64-step mean division on the same
// divider and a 32-step square root, or skips both on the saturated path. Results sit
// in an output register, so the next element is taken while a result still waits on
// rsp_stall. Tolerance registers sit at byte addresses 0x0 (rel_tolerance), 0x4
// (abs_tolerance) and 0x8 (norm_tolerance); they are to be written only while the
// block is idle, which the block itself does not enforce.
module wrms_update_norm_test (
   input  logic                                clock,
   input  logic                                reset,
   // element transactions
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [wrms_pkg::WORD_W-1:0]  req_current_value,
   input  logic signed [wrms_pkg::WORD_W-1:0]  req_previous_value,
   input  logic                                req_last_element,
   input  logic                                req_first_iteration,
   // norm transactions
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [wrms_pkg::WORD_W-1:0]  rsp_norm_value,
   output logic                                rsp_converged,
   output logic                                rsp_norm_saturated,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wrms_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wrms_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wrms_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import wrms_pkg::*;

   logic [WORD_W-1:0] rel_tol_ff;
   logic [WORD_W-1:0] abs_tol_ff;
   logic [WORD_W-1:0] norm_tol_ff;
   logic              csr_write;
   csr_index_type     csr_index;
   wrms_cmd_type      cmd;
   wrms_sts_type      sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // tolerance registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rel_tol_ff  <= REL_TOL_RESET;
         abs_tol_ff  <= ABS_TOL_RESET;
         norm_tol_ff <= NORM_TOL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_REL_TOL:  rel_tol_ff  <= csr_pwdata;
            CSR_ABS_TOL:  abs_tol_ff  <= csr_pwdata;
            CSR_NORM_TOL: norm_tol_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         CSR_REL_TOL:  csr_prdata = rel_tol_ff;
         CSR_ABS_TOL:  csr_prdata = abs_tol_ff;
         CSR_NORM_TOL: csr_prdata = norm_tol_ff;
         default:      csr_prdata = '0;
      endcase
   end

   wrms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wrms_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .rel_tol             (rel_tol_ff),
      .abs_tol             (abs_tol_ff),
      .norm_tol            (norm_tol_ff),
      .req_current_value   (req_current_value),
      .req_previous_value  (req_previous_value),
      .req_last_element    (req_last_element),
      .req_first_iteration (req_first_iteration),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_norm_value      (rsp_norm_value),
      .rsp_converged       (rsp_converged),
      .rsp_norm_saturated  (rsp_norm_saturated)
   );

endmodule

// File: tb/wrms_update_norm_test_test.sv
`timescale 1ns / 1ps

module wrms_update_norm_test_test;
   import wrms_pkg::*;

   localparam int unsigned SETTLE_CYCLES  = 200;
   localparam int unsigned RUN_LIMIT_NS   = 60_000_000;
   localparam int unsigned DIRECTED_COUNT = 20;

   typedef struct packed {
      logic [WORD_W-1:0] norm_value;
      logic              converged;
      logic              norm_saturated;
   } norm_result_type;

   typedef struct packed {
      logic [WORD_W-1:0] current_value;
      logic [WORD_W-1:0] previous_value;
      logic              last_element;
      logic              first_iteration;
   } element_type;

   typedef struct packed {
      element_type     elem;
      logic            known;
      norm_result_type result;
   } directed_row_type;

   localparam norm_result_type MAX_NORM  = '{WORD_MAX, 1'b0, 1'b1};
   localparam norm_result_type ZERO_NORM = '{32'h0, 1'b1, 1'b0};
   localparam norm_result_type UNTYPED   = '0;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [WORD_W-1:0] req_current_value;
   logic signed [WORD_W-1:0] req_previous_value;
   logic                     req_last_element;
   logic                     req_first_iteration;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [WORD_W-1:0]        rsp_norm_value;
   logic                     rsp_converged;
   logic                     rsp_norm_saturated;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [CSR_DATA_W-1:0]    csr_pwdata;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   // tolerance copies and accumulation state of the norm predictor
   logic [WORD_W-1:0] rel_weight;
   logic [WORD_W-1:0] abs_weight;
   logic [WORD_W-1:0] norm_limit;
   logic [SUM_W-1:0]  sum_of_squares;
   int unsigned       elements_seen;
   logic              overflow_seen;

   norm_result_type expected_norms[$];
   int unsigned     mismatch_count;
   logic            idle_enable;
   int unsigned     stall_left;

   // directed vectors, reset tolerances (rtol 66, atol 1, limit 1.0)
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // single zero element converges with zero norm
      '{'{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}, 1'b1, ZERO_NORM},
      '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b1, ZERO_NORM},
      '{'{32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0}, 1'b1, ZERO_NORM},
      // first iteration on the last element
      '{'{32'h0000_0005, 32'h0000_0007, 1'b1, 1'b1}, 1'b1, MAX_NORM},
      // largest differences
      '{'{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0}, 1'b0, UNTYPED},
      '{'{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b0, UNTYPED},
      // quotient clipped with unit weight
      '{'{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b1, MAX_NORM},
      // near-maximum quotient without clipping
      '{'{32'h0000_0000, 32'h0000_FFFF, 1'b1, 1'b0}, 1'b0, UNTYPED},
      // two near-maximum squares overflow the sum
      '{'{32'h0000_0000, 32'h0000_FFFF, 1'b0, 1'b0}, 1'b0, UNTYPED},
      '{'{32'h0000_0000, 32'hFFFF_0001, 1'b1, 1'b0}, 1'b1, MAX_NORM},
      // first iteration flag ignored away from the last element
      '{'{32'h0001_0000, 32'h0001_0001, 1'b0, 1'b1}, 1'b0, UNTYPED},
      '{'{32'hFFFF_0000, 32'hFFFE_FFFF, 1'b0, 1'b0}, 1'b0, UNTYPED},
      '{'{32'h1234_5678, 32'h1234_0000, 1'b1, 1'b0}, 1'b0, UNTYPED},
      '{'{32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, UNTYPED},
      '{'{32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0}, 1'b1, MAX_NORM},
      // norm landing exactly on the limit
      '{'{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, UNTYPED},
      '{'{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, UNTYPED},
      '{'{32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, UNTYPED},
      '{'{32'h4000_0000, 32'h3FFF_0000, 1'b1, 1'b1}, 1'b1, MAX_NORM},
      '{'{32'h0000_0100, 32'h0000_0100, 1'b1, 1'b0}, 1'b1, ZERO_NORM}
   };

   wrms_update_norm_test i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_current_value   (req_current_value),
      .req_previous_value  (req_previous_value),
      .req_last_element    (req_last_element),
      .req_first_iteration (req_first_iteration),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_norm_value      (rsp_norm_value),
      .rsp_converged       (rsp_converged),
      .rsp_norm_saturated  (rsp_norm_saturated),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   function automatic logic [WORD_W-1:0] int_sqrt(input logic [SUM_W-1:0] x);
      logic [WORD_W-1:0] root;
      logic [WORD_W-1:0] trial;
      root = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         trial = root | (32'd1 << i);
         if (64'(trial) * 64'(trial) <= x) root = trial;
      end
      return root;
   endfunction

   // one element into the running sum; returns 1 with the norm on the last element
   function automatic logic accumulate_element(input element_type e,
                                               output norm_result_type r);
      longint            cur;
      longint            prev;
      longint            diff;
      logic [63:0]       mag;
      logic [63:0]       dmag;
      logic [63:0]       weight;
      logic [63:0]       quot;
      logic [63:0]       square;
      logic [WORD_W-1:0] norm;
      cur    = $signed(e.current_value);
      prev   = $signed(e.previous_value);
      mag    = (cur < 0) ? -cur : cur;
      diff   = cur - prev;
      dmag   = (diff < 0) ? -diff : diff;
      weight = ((64'(rel_weight) * mag) >> FRAC_BITS) + 64'(abs_weight);
      r      = '0;
      // quotient clipped at the word maximum, zero weight clips unless no difference
      if (dmag == 0) begin
         quot = 0;
      end else if (weight == 0) begin
         quot = 64'(WORD_MAX);
         overflow_seen = 1'b1;
      end else begin
         quot = (dmag << FRAC_BITS) / weight;
         if (quot > 64'(WORD_MAX)) begin
            quot = 64'(WORD_MAX);
            overflow_seen = 1'b1;
         end
      end
      // saturating sum of squares
      square = quot * quot;
      if (sum_of_squares > SUM_MAX - square) begin
         sum_of_squares = SUM_MAX;
         overflow_seen  = 1'b1;
      end else begin
         sum_of_squares = sum_of_squares + square;
      end
      if (elements_seen < MAX_LENGTH) elements_seen++;
      if (!e.last_element) return 1'b0;
      if (e.first_iteration || overflow_seen) begin
         r = MAX_NORM;
      end else begin
         norm = int_sqrt(sum_of_squares / 64'(elements_seen));
         r    = '{norm, norm < norm_limit, 1'b0};
      end
      sum_of_squares = '0;
      elements_seen  = 0;
      overflow_seen  = 1'b0;
      return 1'b1;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // apb transfer, left in access phase so transfers can run back to back
   task automatic csr_transfer(input csr_index_type idx, input logic write,
                               input logic [WORD_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= write ? value : '0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!write) check_field("register readback", value, csr_prdata);
   endtask

   task automatic set_tolerances(input logic [WORD_W-1:0] rel, input logic [WORD_W-1:0] abs,
                                 input logic [WORD_W-1:0] limit);
      csr_transfer(CSR_REL_TOL, 1'b1, rel);
      csr_transfer(CSR_ABS_TOL, 1'b1, abs);
      csr_transfer(CSR_NORM_TOL, 1'b1, limit);
      csr_transfer(CSR_REL_TOL, 1'b0, rel);
      csr_transfer(CSR_ABS_TOL, 1'b0, abs);
      csr_transfer(CSR_NORM_TOL, 1'b0, limit);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      rel_weight = rel;
      abs_weight = abs;
      norm_limit = limit;
   endtask

   // send one element transaction and record the norm it should produce
   task automatic send_element(input element_type e, input logic known,
                               input norm_result_type fixed);
      norm_result_type r;
      int unsigned     gap;
      gap = idle_enable ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_current_value   <= e.current_value;
      req_previous_value  <= e.previous_value;
      req_last_element    <= e.last_element;
      req_first_iteration <= e.first_iteration;
      do @(posedge clock); while (req_stall);
      if (accumulate_element(e, r)) expected_norms.push_back(known ? fixed : r);
   endtask

   // wait for every norm, then for the block to finish any element in flight
   task automatic drain();
      while (expected_norms.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 4))
         0: w = $urandom;
         1: w = $urandom >> $urandom_range(0, 31);
         2: begin
            case ($urandom_range(0, 5))
               0:       w = 32'h0000_0000;
               1:       w = 32'h0000_0001;
               2:       w = 32'h7FFF_FFFF;
               3:       w = 32'h8000_0000;
               4:       w = 32'hFFFF_FFFF;
               default: w = 32'h0001_0000;
            endcase
         end
         default: w = $urandom_range(0, 32'h00FF_FFFF);
      endcase
      if ($urandom_range(0, 1)) w = -w;
      return w;
   endfunction

   // element pair: equal, unrelated, or previous near current
   function automatic element_type random_element(input int unsigned equal_pct);
      element_type       e;
      logic [WORD_W-1:0] delta;
      e               = '0;
      e.current_value = pick_word();
      delta           = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(1, 100) <= equal_pct)
         e.previous_value = e.current_value;
      else if ($urandom_range(0, 4) == 0)
         e.previous_value = $urandom;
      else if ($urandom_range(0, 1))
         e.previous_value = e.current_value + delta;
      else
         e.previous_value = e.current_value - delta;
      return e;
   endfunction

   // one configuration phase of random vectors
   task automatic run_phase(input logic [WORD_W-1:0] rel, input logic [WORD_W-1:0] abs,
                            input logic [WORD_W-1:0] limit, input int unsigned count,
                            input int unsigned equal_pct, input logic idle);
      int unsigned sent;
      int unsigned len;
      logic        first_vec;
      element_type e;
      drain();
      set_tolerances(rel, abs, limit);
      idle_enable = idle;
      sent        = 0;
      while (sent < count) begin
         len       = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         first_vec = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < len; i++) begin
            e                 = random_element(equal_pct);
            e.last_element    = (i == len - 1);
            e.first_iteration = e.last_element ? first_vec : 1'($urandom_range(0, 1));
            send_element(e, 1'b0, UNTYPED);
         end
         sent += len;
      end
      req_valid <= 1'b0;
   endtask

   // norm transaction checker
   always @(posedge clock) begin
      norm_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_norms.size() == 0) begin
            $display("%0t: unexpected norm transaction, actual %0h conv %0b sat %0b",
                     $time, rsp_norm_value, rsp_converged, rsp_norm_saturated);
            mismatch_count++;
         end else begin
            want = expected_norms.pop_front();
            check_field("norm_value", want.norm_value, rsp_norm_value);
            check_field("converged", 32'(want.converged), 32'(rsp_converged));
            check_field("norm_saturated", 32'(want.norm_saturated), 32'(rsp_norm_saturated));
         end
      end
   end

   // result side stall, quiet when idling is off
   always @(posedge clock) begin
      int unsigned n;
      if (reset || !idle_enable) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         n          = pick_gap();
         rsp_stall  <= (n != 0);
         stall_left = (n != 0) ? n - 1 : 0;
      end
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   // stimulus
   initial begin
      mismatch_count      = 0;
      idle_enable         = 1'b0;
      rel_weight          = REL_TOL_RESET;
      abs_weight          = ABS_TOL_RESET;
      norm_limit          = NORM_TOL_RESET;
      sum_of_squares      = '0;
      elements_seen       = 0;
      overflow_seen       = 1'b0;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_current_value   <= '0;
      req_previous_value  <= '0;
      req_last_element    <= 1'b0;
      req_first_iteration <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed vectors at reset tolerances, with idling
      idle_enable = 1'b1;
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_element(directed_rows[i].elem, directed_rows[i].known, directed_rows[i].result);
      req_valid <= 1'b0;

      // extremes: zero relative weight and zero limit, then all ones
      run_phase(32'h0, 32'h1, 32'h0, 300, 10, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 300, 10, 1'b1);
      // zero weight
      run_phase(32'h0, 32'h0, $urandom, 200, 60, 1'b1);
      // random tolerances
      for (int p = 0; p < 3; p++)
         run_phase($urandom >> $urandom_range(0, 31),
                   ($urandom_range(0, 7) == 0) ? 32'h0 : ($urandom >> $urandom_range(0, 31)) | 1,
                   $urandom >> $urandom_range(0, 24), 330, 10, 1'(p != 1));

      drain();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
